/* rtl/core/qte_pkg.sv */
// qte_pkg: shared widths, payload structs and the arctangent step table
// for the quaternion to euler pipeline. No dependencies.
package qte_pkg;

  localparam int QW         = 16;  // quaternion component width
  localparam int PW         = 32;  // component product width
  localparam int SUMW       = 35;  // numerator and denominator width
  localparam int SW         = 30;  // saturated sine argument width
  localparam int ROOTW      = 29;  // square root width
  localparam int SQW        = 57;  // radicand width
  localparam int MAGW       = 33;  // ratio magnitude width
  localparam int XW         = 44;  // cordic x and y width
  localparam int ZW         = 35;  // cordic angle accumulator width
  localparam int SHW        = 6;   // normalize shift width
  localparam int AW         = 15;  // output angle width
  localparam int NLANE      = 3;
  localparam int NORM_MSB   = 40;
  localparam int RND_SHIFT  = 19;
  localparam int ANG_TAB_SIZE = 32;

  localparam logic [SQW-1:0]         ONE_SQ  = {1'b1, {(SQW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] S_HI    = SUMW'(36'sd268435456);
  localparam logic signed [SUMW-1:0] S_LO    = -SUMW'(36'sd268435456);
  localparam logic signed [SW-1:0]   S_ONE   = SW'(36'sd268435456);
  localparam logic signed [SW-1:0]   S_MONE  = -SW'(36'sd268435456);
  localparam logic signed [AW-1:0]   ANG_MAX = 15'sd12868;
  localparam logic signed [AW-1:0]   ANG_MIN = -15'sd12868;

  typedef struct packed {
    logic signed [SUMW-1:0] rn;
    logic signed [SUMW-1:0] rd;
    logic signed [SUMW-1:0] yn;
    logic signed [SUMW-1:0] yd;
    logic signed [SW-1:0]   s;
    logic                   clamp;
  } qte_side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [MAGW-1:0]      mag;
    logic [SHW-1:0]       sh;
    logic                 zero;
    logic                 npos;
    logic                 nneg;
  } qte_lane_t;

  // atan(2^-i) in units of 2^-32 rad
  function automatic logic [31:0] ang_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'd3373259426;
      5'd1:    v = 32'd1991351318;
      5'd2:    v = 32'd1052175346;
      5'd3:    v = 32'd534100635;
      5'd4:    v = 32'd268086748;
      5'd5:    v = 32'd134174063;
      5'd6:    v = 32'd67103403;
      5'd7:    v = 32'd33553749;
      5'd8:    v = 32'd16777131;
      5'd9:    v = 32'd8388597;
      5'd10:   v = 32'd4194303;
      default: v = 32'h1 << (6'd32 - {1'b0, i});
    endcase
    return v;
  endfunction

  function automatic logic [SHW-1:0] msb_pos(input logic [MAGW-1:0] v);
    logic [SHW-1:0] p;
    p = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (v[i]) begin
        p = SHW'(i);
      end
    end
    return p;
  endfunction

endpackage

/* rtl/core/qte_prep.sv */
// qte_prep: component products, sums, sine saturation and radicand
// for the pitch square root. Depends on qte_pkg.
module qte_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [15:0]            quat_w_i,
  input  logic [15:0]            quat_x_i,
  input  logic [15:0]            quat_y_i,
  input  logic [15:0]            quat_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [qte_pkg::SQW-1:0] rad_o,
  output qte_pkg::qte_side_t     side_o
);
  import qte_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] vld_q;
  logic [NST:0]   adv;
  logic [NST-1:0] vin;

  assign adv[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign vin = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // products
  logic signed [PW-1:0] p_wy_q, p_xz_q, p_wx_q, p_yz_q, p_wz_q, p_xy_q;
  logic signed [PW-1:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [QW-1:0] w, x, y, z;

  assign w = $signed(quat_w_i);
  assign x = $signed(quat_x_i);
  assign y = $signed(quat_y_i);
  assign z = $signed(quat_z_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      p_wy_q <= w * y;
      p_xz_q <= x * z;
      p_wx_q <= w * x;
      p_yz_q <= y * z;
      p_wz_q <= w * z;
      p_xy_q <= x * y;
      p_ww_q <= w * w;
      p_xx_q <= x * x;
      p_yy_q <= y * y;
      p_zz_q <= z * z;
    end
  end

  // sums and saturation
  qte_side_t s1_d, s1_q;
  logic signed [SUMW-1:0] s_full;

  always_comb begin
    s_full   = (SUMW'(p_wy_q) - SUMW'(p_xz_q)) <<< 1;
    s1_d     = '0;
    s1_d.rn  = (SUMW'(p_wx_q) + SUMW'(p_yz_q)) <<< 1;
    s1_d.rd  = SUMW'(p_ww_q) - SUMW'(p_xx_q) - SUMW'(p_yy_q) + SUMW'(p_zz_q);
    s1_d.yn  = (SUMW'(p_wz_q) + SUMW'(p_xy_q)) <<< 1;
    s1_d.yd  = SUMW'(p_ww_q) + SUMW'(p_xx_q) - SUMW'(p_yy_q) - SUMW'(p_zz_q);
    priority if (s_full > S_HI) begin
      s1_d.s     = S_ONE;
      s1_d.clamp = 1'b1;
    end else if (s_full < S_LO) begin
      s1_d.s     = S_MONE;
      s1_d.clamp = 1'b1;
    end else begin
      s1_d.s     = SW'(s_full);
      s1_d.clamp = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q <= s1_d;
    end
  end

  // square of the sine argument
  qte_side_t            s2_q;
  logic [SW-2:0]        s_abs;
  logic [2*(SW-1)-1:0]  sq_full;
  logic [SQW-1:0]       sq_q;

  assign s_abs   = s1_q.s[SW-1] ? (SW-1)'(-s1_q.s) : (SW-1)'(s1_q.s);
  assign sq_full = s_abs * s_abs;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_q <= s1_q;
      sq_q <= sq_full[SQW-1:0];
    end
  end

  // radicand
  qte_side_t      s3_q;
  logic [SQW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_q  <= s2_q;
      rad_q <= ONE_SQ - sq_q;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];
  assign rad_o       = rad_q;
  assign side_o      = s3_q;

endmodule

/* rtl/core/qte_sqrt.sv */
// qte_sqrt: pipelined integer square root, one result bit per stage,
// carrying the roll and yaw terms alongside. Depends on qte_pkg.
module qte_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [qte_pkg::SQW-1:0]   rad_i,
  input  qte_pkg::qte_side_t        side_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [qte_pkg::ROOTW-1:0] root_o,
  output qte_pkg::qte_side_t        side_o
);
  import qte_pkg::*;

  localparam int NST = ROOTW;
  localparam int CW  = 2 * ROOTW + 1;

  logic [NST-1:0] vld_q;
  logic [NST:0]   adv;
  logic [NST-1:0] vin;

  assign adv[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign vin = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  logic [SQW-1:0]   rem_q  [NST];
  logic [ROOTW-1:0] root_q [NST];
  qte_side_t        side_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int B = ROOTW - 1 - k;
    logic [SQW-1:0]   rem_in;
    logic [ROOTW-1:0] root_in;
    qte_side_t        side_in;
    logic [CW-1:0]    cand;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cand = ((CW'(root_in) << 1) + (CW'(1) << B)) << B;
    assign ge   = CW'(rem_in) >= cand;

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        rem_q[k]  <= ge ? SQW'(CW'(rem_in) - cand) : rem_in;
        root_q[k] <= ge ? (root_in | (ROOTW'(1) << B)) : root_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];
  assign root_o      = root_q[NST-1];
  assign side_o      = side_q[NST-1];

endmodule

/* rtl/core/qte_atan.sv */
// qte_atan: three parallel arctangent lanes: sign fix, normalize,
// pipelined vectoring cordic and rounding to Q2.13. Depends on qte_pkg.
module qte_atan #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [qte_pkg::NLANE-1:0][qte_pkg::SUMW-1:0] num_i,
  input  logic [qte_pkg::NLANE-1:0][qte_pkg::SUMW-1:0] den_i,
  input  logic                                     clamp_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [qte_pkg::NLANE-1:0][qte_pkg::AW-1:0]   angle_o,
  output logic [qte_pkg::NLANE-1:0]                zero_o,
  output logic                                     clamp_o
);
  import qte_pkg::*;

  localparam int NST = CORDIC_STEPS + 4;

  logic [NST-1:0] vld_q;
  logic [NST:0]   adv;
  logic [NST-1:0] vin;

  assign adv[NST] = out_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign vin = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  qte_lane_t      st_q    [NST][NLANE];
  logic [NST-1:0] clamp_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        clamp_q[k] <= (k == 0) ? clamp_i : clamp_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      qte_lane_t pv, nx;

      if (k == 0) begin : g_sign
        logic signed [SUMW-1:0] n, d, nn, nd, an;
        assign pv = '0;
        always_comb begin
          n       = $signed(num_i[l]);
          d       = $signed(den_i[l]);
          nn      = d[SUMW-1] ? -n : n;
          nd      = d[SUMW-1] ? -d : d;
          an      = nn[SUMW-1] ? -nn : nn;
          nx      = pv;
          nx.zero = (d == '0);
          nx.npos = !n[SUMW-1] && (n != '0);
          nx.nneg = n[SUMW-1];
          nx.x    = XW'(nd);
          nx.y    = XW'(nn);
          nx.mag  = (an > nd) ? MAGW'(an) : MAGW'(nd);
        end
      end else if (k == 1) begin : g_lzc
        assign pv = st_q[k-1][l];
        always_comb begin
          nx    = pv;
          nx.sh = SHW'(NORM_MSB) - msb_pos(pv.mag);
        end
      end else if (k == 2) begin : g_norm
        assign pv = st_q[k-1][l];
        always_comb begin
          nx   = pv;
          nx.x = pv.x <<< pv.sh;
          nx.y = pv.y <<< pv.sh;
          nx.z = '0;
        end
      end else if (k < NST - 1) begin : g_rot
        localparam int I = k - 3;
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] ang;
        assign pv  = st_q[k-1][l];
        assign xs  = pv.x >>> I;
        assign ys  = pv.y >>> I;
        assign ang = $signed({{(ZW-32){1'b0}}, ang_entry(5'(I))});
        always_comb begin
          nx = pv;
          if (!pv.y[XW-1]) begin
            nx.x = pv.x + ys;
            nx.y = pv.y - xs;
            nx.z = pv.z + ang;
          end else begin
            nx.x = pv.x - ys;
            nx.y = pv.y + xs;
            nx.z = pv.z - ang;
          end
        end
      end else begin : g_rnd
        logic signed [ZW-1:0] r;
        logic signed [AW-1:0] a;
        assign pv = st_q[k-1][l];
        assign r  = (pv.z + (ZW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        always_comb begin
          priority if (pv.zero) begin
            a = pv.npos ? ANG_MAX : (pv.nneg ? ANG_MIN : '0);
          end else if (r > ZW'(ANG_MAX)) begin
            a = ANG_MAX;
          end else if (r < ZW'(ANG_MIN)) begin
            a = ANG_MIN;
          end else begin
            a = AW'(r);
          end
          nx   = pv;
          nx.z = ZW'(a);
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          st_q[k][l] <= nx;
        end
      end
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_out
    assign angle_o[l] = st_q[NST-1][l].z[AW-1:0];
    assign zero_o[l]  = st_q[NST-1][l].zero;
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];
  assign clamp_o     = clamp_q[NST-1];

endmodule

/* rtl/core/quaternion_to_euler_unit.sv */
// quaternion_to_euler_unit: top level, quaternion in, pitch/roll/yaw out.
// Depends on qte_pkg, qte_prep, qte_sqrt and qte_atan.
//
//   channel   direction  tdata fields (lsb first)
//   s_axis    in         quat_w, quat_x, quat_y, quat_z (16 b each)
//   m_axis    out        pitch_angle, roll_angle, yaw_angle (15 b each),
//                        asin_clamped, zero_divisor, one pad bit
//
// one item per cycle sustained while m_axis_tready stays high; the pipeline
// has 4 product stages, 29 square root stages, 3 normalize stages, one
// stage per cordic step and one rounding stage
// rst_ni clears all stage valid bits; data registers are not reset
// each stage holds when the one after it is full and stalled, so bubbles close up
module quaternion_to_euler_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // pitch, roll, yaw, asin_clamped, zero_divisor, pad
);
  import qte_pkg::*;

  logic           prep_valid, prep_ready;
  logic [SQW-1:0] prep_rad;
  qte_side_t      prep_side;

  qte_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .quat_w_i    (s_axis_tdata[15:0]),
    .quat_x_i    (s_axis_tdata[31:16]),
    .quat_y_i    (s_axis_tdata[47:32]),
    .quat_z_i    (s_axis_tdata[63:48]),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .rad_o       (prep_rad),
    .side_o      (prep_side)
  );

  logic             sq_valid, sq_ready;
  logic [ROOTW-1:0] sq_root;
  qte_side_t        sq_side;

  qte_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .rad_i       (prep_rad),
    .side_i      (prep_side),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  logic [NLANE-1:0][SUMW-1:0] num, den;
  logic [NLANE-1:0][AW-1:0]   angle;
  logic [NLANE-1:0]           zero;
  logic                       clamp;
  logic [AW-1:0]              roll;

  assign num[0] = SUMW'(sq_side.s);
  assign den[0] = SUMW'(sq_root);
  assign num[1] = sq_side.rn;
  assign den[1] = sq_side.rd;
  assign num[2] = sq_side.yn;
  assign den[2] = sq_side.yd;

  qte_atan #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_atan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .num_i       (num),
    .den_i       (den),
    .clamp_i     (sq_side.clamp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .angle_o     (angle),
    .zero_o      (zero),
    .clamp_o     (clamp)
  );

  assign roll         = AW'(-$signed(angle[1]));
  assign m_axis_tdata = {1'b0, zero[1] | zero[2], clamp, angle[2], roll, angle[0]};

endmodule

/* rtl/core/qte_checker.sv */
// qte_checker: port-level assertions for quaternion_to_euler_unit and the
// bind that attaches them. Depends on quaternion_to_euler_unit.
module qte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic signed [14:0] pitch, yaw;
  logic               in_seen;

  assign pitch   = $signed(m_axis_tdata[14:0]);
  assign yaw     = $signed(m_axis_tdata[44:30]);
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 64'h0 || 1'b1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (yaw <= 15'sd12868) && (yaw >= -15'sd12868))
    else $error("yaw out of range");

  a_clamp_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[45] |-> (pitch == 15'sd12868) || (pitch == -15'sd12868))
    else $error("saturated sine argument without full pitch");

  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid || in_seen)
    else $error("result item right after reset");

endmodule

bind quaternion_to_euler_unit qte_checker u_qte_checker (.*);

/* dv/tb_quaternion_to_euler_unit.sv */
// tb_quaternion_to_euler_unit: self-checking testbench for the quaternion to
// euler angle unit; depends on quaternion_to_euler_unit and the qte_pkg it pulls in
module tb_quaternion_to_euler_unit;

  localparam int STEPS    = 16;
  localparam int HALF_PI  = 12868;
  localparam int N_RANDOM = 930;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [14:0] yaw;
    logic               clamped;
    logic               zero_div;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    bit                 known;
    angles_t            ang;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  longint      atan_step[32];
  angles_t     pending_angles[$];
  int          n_errors;
  int          n_results;
  int          n_clamped;
  int          n_zero_div;
  int          n_cycles;
  bit          timed_out;

  quaternion_to_euler_unit #(.CORDIC_STEPS(STEPS)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // atan(1/n) scaled by 2^60
  function automatic longint atan_inv(longint unsigned n);
    longint unsigned p, nn, k;
    longint          sum;
    p   = (64'd1 << 60) / n;
    nn  = n * n;
    k   = 0;
    sum = 0;
    while (p != 0) begin
      if (k[0]) sum = sum - longint'(p / (2 * k + 1));
      else sum = sum + longint'(p / (2 * k + 1));
      p = p / nn;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int vector_atan(longint n, longint d, ref bit zero_div);
    longint cx, cy, acc, mag, xs, ys, r;
    if (d == 0) begin
      zero_div = 1'b1;
      return n > 0 ? HALF_PI : (n < 0 ? -HALF_PI : 0);
    end
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    forever begin
      mag = n < 0 ? -n : n;
      if (d > mag) mag = d;
      if (mag >= (64'sd1 <<< 40)) break;
      n = n * 2;
      d = d * 2;
    end
    cx  = d;
    cy  = n;
    acc = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + ys;
        cy  = cy - xs;
        acc = acc + atan_step[i];
      end else begin
        cx  = cx - ys;
        cy  = cy + xs;
        acc = acc - atan_step[i];
      end
    end
    r = (acc + (64'sd1 <<< 18)) >>> 19;
    if (r > HALF_PI) r = HALF_PI;
    if (r < -HALF_PI) r = -HALF_PI;
    return int'(r);
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint  w, x, y, z, s, one;
    bit      zd, dummy;
    angles_t a;
    w   = longint'($signed(q[15:0]));
    x   = longint'($signed(q[31:16]));
    y   = longint'($signed(q[47:32]));
    z   = longint'($signed(q[63:48]));
    one = 64'sd1 <<< 28;
    zd  = 1'b0;
    dummy = 1'b0;
    a.clamped = 1'b0;
    s = 2 * (w * y - x * z);
    if (s > one) begin
      s = one;
      a.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one;
      a.clamped = 1'b1;
    end
    a.pitch = 15'(vector_atan(s, longint'(int_sqrt(longint'(one * one - s * s))), dummy));
    a.roll  = 15'(-vector_atan(2 * (w * x + y * z), w * w - x * x - y * y + z * z, zd));
    a.yaw   = 15'(vector_atan(2 * (w * z + x * y), w * w + x * x - y * y - z * z, zd));
    a.zero_div = zd;
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // result checker and accepted-item bookkeeping
  always @(posedge clk_i) begin
    angles_t e;
    n_cycles <= n_cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_angles.push_back(euler_of(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("item with nothing pending", 1, 0);
      end else begin
        e = pending_angles.pop_front();
        if ($signed(m_axis_tdata[14:0]) != e.pitch)
          report_mismatch("pitch", $signed(m_axis_tdata[14:0]), e.pitch);
        if ($signed(m_axis_tdata[29:15]) != e.roll)
          report_mismatch("roll", $signed(m_axis_tdata[29:15]), e.roll);
        if ($signed(m_axis_tdata[44:30]) != e.yaw)
          report_mismatch("yaw", $signed(m_axis_tdata[44:30]), e.yaw);
        if (m_axis_tdata[45] != e.clamped)
          report_mismatch("asin_clamped", m_axis_tdata[45], e.clamped);
        if (m_axis_tdata[46] != e.zero_div)
          report_mismatch("zero_divisor", m_axis_tdata[46], e.zero_div);
        n_clamped  += e.clamped;
        n_zero_div += e.zero_div;
      end
      n_results++;
    end
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int rx_cyc;
    m_axis_tready = 1'b0;
    rx_cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (rx_cyc >= 300 && rx_cyc < 500) m_axis_tready <= 1'b0;
      else if (n_cycles >= 900 && n_cycles < 1300) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 30);
    end
  end

  task automatic send_quat(logic [63:0] d);
    while (!(n_cycles >= 900 && n_cycles < 1300) && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic stim_row_t row(int w, int x, int y, int z, bit known = 0,
                                    int p = 0, int r = 0, int yw = 0,
                                    bit c = 0, bit zd = 0);
    stim_row_t t;
    t.w = 16'(w); t.x = 16'(x); t.y = 16'(y); t.z = 16'(z);
    t.known = known;
    t.ang.pitch = 15'(p); t.ang.roll = 15'(r); t.ang.yaw = 15'(yw);
    t.ang.clamped = c; t.ang.zero_div = zd;
    return t;
  endfunction

  initial begin
    stim_row_t   directed[$];
    angles_t     a;
    logic [63:0] d;
    real         fw, fx, fy, fz, nrm;
    int          guard;

    n_errors = 0; n_results = 0; n_clamped = 0; n_zero_div = 0; n_cycles = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;

    for (int i = 0; i < 32; i++) begin
      longint v;
      if (i == 0) v = 4 * atan_inv(5) - atan_inv(239);
      else v = atan_inv(64'd1 << i);
      atan_step[i] = (v + (64'sd1 <<< 27)) >>> 28;
    end

    directed.push_back(row(16384, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
    directed.push_back(row(16384, 0, 16384, 0, 1, HALF_PI, 0, 0, 1, 1));
    directed.push_back(row(0, 16384, 0, 0));
    directed.push_back(row(0, 0, 16384, 0));
    directed.push_back(row(0, 0, 0, 16384));
    directed.push_back(row(-16384, 0, 0, 0));
    directed.push_back(row(11585, 11585, 0, 0));
    directed.push_back(row(11585, 0, 11585, 0));
    directed.push_back(row(11585, 0, -11585, 0));
    directed.push_back(row(11585, 0, 0, 11585));
    directed.push_back(row(11585, 0, 0, -11585));
    directed.push_back(row(8192, 8192, 8192, 8192));
    directed.push_back(row(8192, -8192, 8192, -8192));
    directed.push_back(row(32767, 32767, 32767, 32767));
    directed.push_back(row(-32768, -32768, -32768, -32768));
    directed.push_back(row(32767, -32768, 32767, -32768));
    directed.push_back(row(-32768, 32767, 32767, -32768));
    directed.push_back(row(0, 11585, 0, 11585));
    directed.push_back(row(16384, 16384, 16384, 16384));
    directed.push_back(row(-16384, 16384, -16384, 16384));
    directed.push_back(row(1, 0, 0, 0));
    directed.push_back(row(-1, -1, -1, -1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      d = {directed[i].z, directed[i].y, directed[i].x, directed[i].w};
      if (directed[i].known) begin
        a = euler_of(d);
        if (a != directed[i].ang) begin
          report_mismatch($sformatf("predictor on known row %0d", i),
                          int'(a.pitch), int'(directed[i].ang.pitch));
        end
      end
      send_quat(d);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(9))
        0, 1: d = {$urandom(), $urandom()};
        2, 3: d = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                   16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384)};
        default: begin
          fw = real'($urandom_range(2000)) - 1000.0;
          fx = real'($urandom_range(2000)) - 1000.0;
          fy = real'($urandom_range(2000)) - 1000.0;
          fz = real'($urandom_range(2000)) - 1000.0;
          if ($urandom_range(3) == 0) fx = 0.0;
          if ($urandom_range(3) == 0) fz = 0.0;
          nrm = $sqrt(fw * fw + fx * fx + fy * fy + fz * fz);
          if (nrm == 0.0) begin
            fw = 1.0;
            nrm = 1.0;
          end
          d = {16'($rtoi(16384.0 * fz / nrm)), 16'($rtoi(16384.0 * fy / nrm)),
               16'($rtoi(16384.0 * fx / nrm)), 16'($rtoi(16384.0 * fw / nrm))};
        end
      endcase
      send_quat(d);
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (pending_angles.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    timed_out = (pending_angles.size() != 0);
    repeat (100) @(posedge clk_i);

    $display("covered %0d quaternions: extremes, axis rotations, random unit and raw",
             n_results);
    $display("saw %0d saturated pitch arguments and %0d zero denominators",
             n_clamped, n_zero_div);
    if (n_errors == 0 && !timed_out) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/qte_pkg.sv
rtl/core/qte_prep.sv
rtl/core/qte_sqrt.sv
rtl/core/qte_atan.sv
rtl/core/quaternion_to_euler_unit.sv
rtl/core/qte_checker.sv
dv/tb_quaternion_to_euler_unit.sv
